FILE: rtl/irsf_pkg.sv
// irsf_pkg: shared types, register indexes and constants for the ir range sensor filter
// used by ir_range_sensor_filter_top; depends on nothing else
`default_nettype none

package irsf_pkg;

   // sample ring
   localparam int RING_DEPTH = 8;   // power of two, 1 .. 64
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int MEAN_SHIFT = $clog2(RING_DEPTH);

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int DIST_W   = 11;
   localparam int TOTAL_W  = SAMPLE_W + MEAN_SHIFT;
   localparam int CUTOFF_W = 11;
   localparam int TYPE_W   = 2;
   localparam int CSR_W    = 11;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 40;

   // register indexes
   localparam logic CSR_SENSOR_TYPE = 1'b0;
   localparam logic CSR_CUTOFF_MM   = 1'b1;

   // sensor types
   localparam logic [TYPE_W-1:0] TYPE_PROXIMITY = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_MEDIUM    = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_LONG      = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_ANALOG    = 2'd3;

   // linearization constants
   localparam int DIVIDEND_W = 20;
   localparam int DIVISOR_W  = 13;
   localparam int DIV_STEPS  = DIST_W;
   localparam int DIV_CNT_W  = 4;
   localparam logic [DIVIDEND_W-1:0] MED_NUMER  = 20'd48000;
   localparam logic [DIVIDEND_W-1:0] LONG_NUMER = 20'd946200;
   localparam logic [DIVISOR_W-1:0]  MED_OFFSET = 13'd20;
   localparam logic [13:0]           LONG_OFFSET = 14'd169;
   localparam logic [SAMPLE_W-1:0]   BAND_LOW   = 10'd80;
   localparam logic [SAMPLE_W-1:0]   MED_HIGH   = 10'd600;
   localparam logic [SAMPLE_W-1:0]   LONG_HIGH  = 10'd490;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } irsf_state_type;

endpackage

`default_nettype wire

FILE: rtl/ir_range_sensor_filter_top.sv
// ir_range_sensor_filter_top: sample ring, running mean and reciprocal distance law
// depends on irsf_pkg
`default_nettype none

// usage
//   req channel: one request carries a 10-bit converter sample and the pin level
//   rsp channel: one result per request, in request order
//   csr port: sensor_type (index 0) and cutoff_mm (index 1), written while idle
// sequence
//   proximity type: straight to the finish state, where the result is registered
//   analog types: ring read, update, band check, then an 11-step restoring
//   divider, and the result is registered in the finish state; the divider is
//   skipped when the mean lies outside the band or the type is plain analog
// flow
//   one request at a time; the restoring divider loop yields one quotient bit per cycle
// reset
//   synchronous, active high; ring entries read as zero through per-entry
//   valid bits cleared at once, no sweep; sensor_type returns to medium range
// stall
//   the result register holds while rsp_tready is low; a new request is still
//   taken and worked on, and waits in the finish state for the register to free
module ir_range_sensor_filter_top (
   input  wire                         clock,
   input  wire                         reset,
   // request channel
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [irsf_pkg::REQ_W-1:0]  req_tdata,   // adc_sample[9:0], pin_level[10], zero
   // result channel
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [irsf_pkg::RSP_W-1:0]  rsp_tdata,   // found_object[0], distance_mm[11:1],
                                                    // raw_value[21:12],
                                                    // processed_value[31:22],
                                                    // within_cutoff[32], zero
   // configuration port
   input  wire                         csr_we,
   input  wire                         csr_index,
   input  wire  [irsf_pkg::CSR_W-1:0]  csr_wdata
);
   import irsf_pkg::*;

   // configuration
   logic [TYPE_W-1:0]   sensor_type_ff;
   logic [CUTOFF_W-1:0] cutoff_ff;

   // sequencer
   irsf_state_type state_ff, state_in;

   // ring memory with one valid bit per entry
   logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic [RING_DEPTH-1:0] ring_valid_ff;
   logic [RING_AW-1:0]    slot_ff;
   logic [TOTAL_W-1:0]    total_ff;

   // request and working registers
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  prox_ff;
   logic                  found_ff;
   logic [SAMPLE_W-1:0]   mean_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIST_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff;

   // control outputs of the sequencer
   logic req_take;
   logic mem_rd;
   logic mem_wr;
   logic rsp_load;

   // request fields
   logic [SAMPLE_W-1:0] req_sample;
   logic                req_pin;
   assign req_sample = req_tdata[SAMPLE_W-1:0];
   assign req_pin    = req_tdata[SAMPLE_W];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_type_ff <= TYPE_MEDIUM;
         cutoff_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SENSOR_TYPE: sensor_type_ff <= csr_wdata[TYPE_W-1:0];
            CSR_CUTOFF_MM:   cutoff_ff      <= csr_wdata[CUTOFF_W-1:0];
            default:         cutoff_ff      <= cutoff_ff;
         endcase
      end
   end

   // ring update: the old entry leaves the total, the new sample enters it
   logic [SAMPLE_W-1:0] old_sample;
   logic [TOTAL_W-1:0]  total_in;
   logic [SAMPLE_W-1:0] mean_in;
   logic [RING_AW-1:0]  slot_in;
   assign old_sample = ring_valid_ff[slot_ff] ? rd_data_ff : '0;
   assign total_in   = total_ff - TOTAL_W'(old_sample) + TOTAL_W'(sample_ff);
   assign mean_in    = total_in[MEAN_SHIFT +: SAMPLE_W];
   assign slot_in    = (slot_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // band check and divider operands from the mean
   logic                  med_ok;
   logic                  long_ok;
   logic                  band_ok;
   logic [13:0]           long_scaled;
   logic [DIVISOR_W-1:0]  divisor_in;
   logic [DIVIDEND_W-1:0] dividend_in;
   always_comb begin
      med_ok      = (mean_ff >= BAND_LOW) && (mean_ff <= MED_HIGH);
      long_ok     = (mean_ff >= BAND_LOW) && (mean_ff <= LONG_HIGH);
      long_scaled = {1'b0, mean_ff, 3'b000} + {3'b000, mean_ff, 1'b0} - LONG_OFFSET;
      case (sensor_type_ff)
         TYPE_MEDIUM: begin
            band_ok     = med_ok;
            divisor_in  = DIVISOR_W'(mean_ff) - MED_OFFSET;
            dividend_in = MED_NUMER;
         end
         TYPE_LONG: begin
            band_ok     = long_ok;
            divisor_in  = long_scaled[DIVISOR_W-1:0];
            dividend_in = LONG_NUMER;
         end
         default: begin
            band_ok     = 1'b0;
            divisor_in  = MED_OFFSET;
            dividend_in = MED_NUMER;
         end
      endcase
   end

   // one restoring step; the quotient register also holds the low dividend bits
   logic [DIVISOR_W:0]   div_shift;
   logic [DIVISOR_W:0]   div_diff;
   logic                 div_bit;
   assign div_shift = {rem_ff, quo_ff[DIST_W-1]};
   assign div_diff  = div_shift - {1'b0, divisor_ff};
   assign div_bit   = ~div_diff[DIVISOR_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (sensor_type_ff == TYPE_PROXIMITY) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: state_in = ST_PREP;
         ST_PREP: state_in = band_ok ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mem_rd     = 1'b0;
      mem_wr     = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_rd     = req_tvalid && (sensor_type_ff != TYPE_PROXIMITY);
         end
         ST_READ: mem_wr = 1'b1;
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end
   assign req_take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      if (mem_rd) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
   end

   // ring bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         slot_ff       <= '0;
         total_ff      <= '0;
      end else if (mem_wr) begin
         ring_valid_ff[slot_ff] <= 1'b1;
         slot_ff                <= slot_in;
         total_ff               <= total_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
         prox_ff   <= (sensor_type_ff == TYPE_PROXIMITY);
         found_ff  <= (sensor_type_ff == TYPE_PROXIMITY) && !req_pin;
         mean_ff   <= '0;
         quo_ff    <= '0;
      end
      case (state_ff)
         ST_READ: mean_ff <= mean_in;
         ST_PREP: begin
            found_ff   <= band_ok;
            divisor_ff <= divisor_in;
            div_cnt_ff <= '0;
            if (band_ok) begin
               rem_ff <= DIVISOR_W'(dividend_in[DIVIDEND_W-1:DIST_W]);
               quo_ff <= dividend_in[DIST_W-1:0];
            end
         end
         ST_DIV: begin
            rem_ff     <= div_bit ? div_diff[DIVISOR_W-1:0] : div_shift[DIVISOR_W-1:0];
            quo_ff     <= {quo_ff[DIST_W-2:0], div_bit};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         default: begin
            div_cnt_ff <= div_cnt_ff;
         end
      endcase
   end

   // result register
   logic              near;
   logic [RSP_W-1:0]  rsp_pack;
   assign near     = found_ff && (quo_ff <= cutoff_ff);
   assign rsp_pack = {7'd0,
                      near,
                      prox_ff ? {SAMPLE_W{1'b0}} : mean_ff,
                      prox_ff ? {SAMPLE_W{1'b0}} : sample_ff,
                      quo_ff,
                      found_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_pack;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a found object in either band always maps to a nonzero distance
   a_found_has_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_pack[0] && !prox_ff |-> rsp_pack[DIST_W:1] != '0)
      else $error("found object with zero distance");

   // the cutoff flag never stands without a found object
   a_near_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[32] |-> rsp_data_ff[0])
      else $error("within cutoff without found object");

   // the divider never runs past its step count
   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_cnt_ff < DIV_CNT_W'(DIV_STEPS))
      else $error("divider step count overrun");

   // the ring is written only in the cycle after its read
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> $past(mem_rd))
      else $error("ring write without preceding read");

endmodule

`default_nettype wire
